// ===== rtl/ccsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccsm_pkg
// Shared types, codes and helpers for the character class scan/move block.
// ----------------------------------------------------------------------------
package ccsm_pkg;

  // input op codes
  localparam logic [1:0] OP_LOAD_CLASS = 2'd0;
  localparam logic [1:0] OP_LOAD_SHIFT = 2'd1;
  localparam logic [1:0] OP_DATA       = 2'd2;

  // class codes
  localparam logic [3:0] CLS_NUMERIC = 4'd0;
  localparam logic [3:0] CLS_UPPER   = 4'd1;
  localparam logic [3:0] CLS_LOWER   = 4'd2;
  localparam logic [3:0] CLS_GRAPH   = 4'd3;
  localparam logic [3:0] CLS_CONTROL = 4'd5;
  localparam logic [3:0] CLS_LEAD    = 4'd6;

  localparam logic [5:0] ALL_CLASSES = 6'h3f;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_CLASS = 2'd1;
  localparam logic [1:0] ST_LEAD_LAST = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_CLASS_SELECT  = 3'd0;
  localparam logic [2:0] CFG_STOP_ON_MATCH = 3'd1;
  localparam logic [2:0] CFG_CASE_SHIFT    = 3'd2;
  localparam logic [2:0] CFG_MOVE_ENABLE   = 3'd3;
  localparam logic [2:0] CFG_BUFFER_LENGTH = 3'd4;

  typedef enum logic [1:0] {
    KIND_LOAD_CLASS,
    KIND_LOAD_SHIFT,
    KIND_DATA
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  index;
    logic [7:0]  value;
    logic [7:0]  data;
    logic        start;
  } q_item_t;

  typedef struct packed {
    logic [5:0]  class_select;
    logic        stop_on_match;
    logic [1:0]  case_shift;
    logic        move_enable;
    logic [14:0] buffer_length;
  } cfg_t;

  function automatic logic class_matches(input logic [5:0] sel, input logic [3:0] cls);
    logic m;
    m = 1'b0;
    if (sel[0] && cls == CLS_UPPER) m = 1'b1;
    if (sel[1] && cls == CLS_LOWER) m = 1'b1;
    if (sel[2] && cls == CLS_NUMERIC) m = 1'b1;
    if (sel[3] && cls >= CLS_GRAPH && cls <= CLS_CONTROL) m = 1'b1;
    if (sel[4] && cls <= CLS_CONTROL) m = 1'b1;
    if (sel[5] && cls == CLS_LEAD) m = 1'b1;
    return m;
  endfunction

endpackage

// ===== rtl/ccsm_front.sv =====
// ----------------------------------------------------------------------------
// ccsm_front
// Input side: decodes each accepted word into a queue entry, drops op three.
// ----------------------------------------------------------------------------
module ccsm_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        op_i,
  input  logic [7:0]        table_index_i,
  input  logic [7:0]        table_value_i,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_buffer_i,
  output logic              push_o,
  output ccsm_pkg::q_item_t push_item_o,
  input  logic              q_ready_i
);
  import ccsm_pkg::*;

  logic keep;

  always_comb begin
    keep = 1'b1;
    push_item_o.kind  = KIND_DATA;
    push_item_o.index = table_index_i;
    push_item_o.value = table_value_i;
    push_item_o.data  = data_byte_i;
    push_item_o.start = start_of_buffer_i;
    unique case (op_i)
      OP_LOAD_CLASS: push_item_o.kind = KIND_LOAD_CLASS;
      OP_LOAD_SHIFT: push_item_o.kind = KIND_LOAD_SHIFT;
      OP_DATA:       push_item_o.kind = KIND_DATA;
      default:       keep = 1'b0;   // unused op: taken and discarded
    endcase
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i && keep;

endmodule

// ===== rtl/ccsm_queue.sv =====
// ----------------------------------------------------------------------------
// ccsm_queue
// Small FIFO between the front and back halves.
// ----------------------------------------------------------------------------
module ccsm_queue #(
  parameter int Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ccsm_pkg::q_item_t push_item_i,
  output logic              ready_o,
  output logic              valid_o,
  output ccsm_pkg::q_item_t pop_item_o,
  input  logic              pop_i
);
  import ccsm_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  q_item_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o    = cnt_q != FullCnt;
  assign valid_o    = cnt_q != '0;
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== rtl/ccsm_back.sv =====
// ----------------------------------------------------------------------------
// ccsm_back
// Execution side: table memories, scan state and the output register.
// ----------------------------------------------------------------------------
module ccsm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccsm_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  input  ccsm_pkg::q_item_t item_i,
  output logic              item_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              write_enable_o,
  output logic              finished_o,
  output logic [14:0]       char_count_o,
  output logic [1:0]        status_o
);
  import ccsm_pkg::*;

  logic [3:0] class_mem [256];
  logic [7:0] shift_mem [256];

  // lookup stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_start_q;
  logic [3:0] cls_q;
  logic [7:0] shv_q;

  // scan state
  logic [14:0] pos_q, pos_d;
  logic        trail_q, trail_d;
  logic        stopped_q, stopped_d;

  // output register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_we_q, out_fin_q;
  logic [14:0] out_cnt_q;
  logic [1:0]  out_st_q;

  logic        has_res, out_free, s1_go, s1_free;
  logic [14:0] pos, pos_inc;
  logic        trail, mv;
  logic [7:0]  ob;
  logic [7:0]  r_byte;
  logic        r_we, r_fin;
  logic [14:0] r_cnt;
  logic [1:0]  r_st;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && (!has_res || out_free);
  assign s1_free    = !s1_valid_q || s1_go;
  assign item_pop_o = item_valid_i && s1_free;

  // loads complete here; later words read the updated entry
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      unique case (item_i.kind)
        KIND_LOAD_CLASS: class_mem[item_i.index] <= item_i.value[3:0];
        KIND_LOAD_SHIFT: shift_mem[item_i.index] <= item_i.value;
        KIND_DATA: begin
          cls_q      <= class_mem[item_i.data];
          shv_q      <= shift_mem[item_i.data];
          s1_byte_q  <= item_i.data;
          s1_start_q <= item_i.start;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= item_pop_o && (item_i.kind == KIND_DATA);
    end
  end

  always_comb begin
    pos     = s1_start_q ? 15'd0 : pos_q;
    trail   = s1_start_q ? 1'b0 : trail_q;
    pos_inc = pos + 15'd1;
    mv      = cfg_i.move_enable;
    ob      = (cfg_i.case_shift != 2'd0 && cls_q != CLS_LEAD) ? shv_q : s1_byte_q;
    has_res = s1_start_q || !stopped_q;

    pos_d     = pos;
    trail_d   = trail;
    stopped_d = 1'b0;
    r_byte    = 8'd0;
    r_we      = 1'b0;
    r_fin     = 1'b0;
    r_cnt     = 15'd0;
    r_st      = ST_OK;

    if (!has_res) begin
      // stopped and no start mark: word dropped
      pos_d     = pos_q;
      trail_d   = trail_q;
      stopped_d = stopped_q;
    end else if (pos >= cfg_i.buffer_length) begin
      stopped_d = 1'b1;
      r_fin     = 1'b1;
      r_cnt     = pos;
    end else if (trail) begin
      // trailing byte of a pair: copied untested, unshifted
      trail_d = 1'b0;
      pos_d   = pos_inc;
      r_byte  = mv ? s1_byte_q : 8'd0;
      r_we    = mv;
      if (pos_inc >= cfg_i.buffer_length) begin
        stopped_d = 1'b1;
        r_fin     = 1'b1;
        r_cnt     = pos_inc;
      end
    end else if (cfg_i.class_select != ALL_CLASSES && cfg_i.class_select != 6'd0 &&
                 cls_q > CLS_LEAD) begin
      stopped_d = 1'b1;
      r_fin     = 1'b1;
      r_st      = ST_BAD_CLASS;
    end else if (cfg_i.class_select != ALL_CLASSES &&
                 class_matches(cfg_i.class_select, cls_q) == cfg_i.stop_on_match) begin
      stopped_d = 1'b1;
      r_fin     = 1'b1;
      r_cnt     = pos;
    end else if (cls_q == CLS_LEAD) begin
      r_byte = mv ? ob : 8'd0;
      r_we   = mv;
      if (pos_inc >= cfg_i.buffer_length) begin
        stopped_d = 1'b1;
        r_fin     = 1'b1;
        r_cnt     = pos;
        r_st      = ST_LEAD_LAST;
      end else begin
        trail_d = 1'b1;
        pos_d   = pos_inc;
      end
    end else begin
      pos_d  = pos_inc;
      r_byte = mv ? ob : 8'd0;
      r_we   = mv;
      if (pos_inc >= cfg_i.buffer_length) begin
        stopped_d = 1'b1;
        r_fin     = 1'b1;
        r_cnt     = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      trail_q   <= 1'b0;
      stopped_q <= 1'b1;
    end else if (s1_go) begin
      pos_q     <= pos_d;
      trail_q   <= trail_d;
      stopped_q <= stopped_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && has_res) begin
      out_byte_q <= r_byte;
      out_we_q   <= r_we;
      out_fin_q  <= r_fin;
      out_cnt_q  <= r_cnt;
      out_st_q   <= r_st;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign write_enable_o = out_we_q;
  assign finished_o     = out_fin_q;
  assign char_count_o   = out_cnt_q;
  assign status_o       = out_st_q;

endmodule

// ===== rtl/char_class_scan_move.sv =====
// ----------------------------------------------------------------------------
// char_class_scan_move
// Table driven byte scanner and copier, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per item: a class
//   table load, a shift table load, or a buffer data byte. Loads produce no
//   output and apply to every later data byte. Op three is taken and dropped.
//   Output channel (out_valid_o/out_ready_i) carries one result per data byte
//   of a running scan. Config channel (cfg_valid_i/cfg_ready_o) writes the
//   scan registers; it is always ready. The user must write it only while
//   idle; the block does not enforce this.
// Path: queue write, table read, then scan stage into the output register.
// Throughput: one word per cycle while the output is not stalled; the table
//   memories are read and the scan state updates once per data byte.
// Reset: scan is stopped, queue empty, registers at defaults; table contents
//   hold no defined value until loaded.
// Receiver stall: the output register holds its word, the scan stage and the
//   queue back up, and in_ready_o drops once the queue is full.
// ----------------------------------------------------------------------------
module char_class_scan_move #(
  parameter int QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_buffer_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        write_enable_o,
  output logic        finished_o,
  output logic [14:0] char_count_o,
  output logic [1:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);
  import ccsm_pkg::*;

  cfg_t    cfg_q;
  q_item_t push_item, pop_item;
  logic    push, q_ready, q_valid, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class_select  <= 6'd0;
      cfg_q.stop_on_match <= 1'b0;
      cfg_q.case_shift    <= 2'd0;
      cfg_q.move_enable   <= 1'b0;
      cfg_q.buffer_length <= 15'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CLASS_SELECT:  cfg_q.class_select  <= cfg_data_i[5:0];
        CFG_STOP_ON_MATCH: cfg_q.stop_on_match <= cfg_data_i[0];
        CFG_CASE_SHIFT:    cfg_q.case_shift    <= cfg_data_i[1:0];
        CFG_MOVE_ENABLE:   cfg_q.move_enable   <= cfg_data_i[0];
        CFG_BUFFER_LENGTH: cfg_q.buffer_length <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ccsm_front u_front (
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .table_index_i     (table_index_i),
    .table_value_i     (table_value_i),
    .data_byte_i       (data_byte_i),
    .start_of_buffer_i (start_of_buffer_i),
    .push_o            (push),
    .push_item_o       (push_item),
    .q_ready_i         (q_ready)
  );

  ccsm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  ccsm_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (q_valid),
    .item_i         (pop_item),
    .item_pop_o     (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .write_enable_o (write_enable_o),
    .finished_o     (finished_o),
    .char_count_o   (char_count_o),
    .status_o       (status_o)
  );

endmodule

// ===== rtl/ccsm_checker.sv =====
// ----------------------------------------------------------------------------
// ccsm_checker
// Port level checks on the result words of char_class_scan_move.
// ----------------------------------------------------------------------------
module ccsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  out_byte_o,
  input logic        write_enable_o,
  input logic        finished_o,
  input logic [14:0] char_count_o,
  input logic [1:0]  status_o
);
  import ccsm_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_enable_o |-> out_byte_o == 8'd0)
    else $error("byte nonzero without write");

  a_err_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> finished_o)
    else $error("error status on unfinished word");

  a_bad_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_BAD_CLASS |-> char_count_o == 15'd0 && !write_enable_o)
    else $error("invalid class word carries count or write");

  a_cnt_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o |-> char_count_o == 15'd0)
    else $error("count on unfinished word");

endmodule

bind char_class_scan_move ccsm_checker u_ccsm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .write_enable_o (write_enable_o),
  .finished_o     (finished_o),
  .char_count_o   (char_count_o),
  .status_o       (status_o)
);

// ===== tb/char_class_scan_move_tb.sv =====
// ----------------------------------------------------------------------------
// char_class_scan_move_tb
// Self-checking bench for the table driven byte scanner/copier. A tracker
// class mirrors the class/shift tables, the scan state and the registers.
// It predicts one result word per data byte of a running scan and checks
// every word taken from the output channel in order. Stimulus is a short
// directed pass, then random phases of buffers under changing settings.
// ----------------------------------------------------------------------------
module char_class_scan_move_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccsm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]  wbyte;
    logic        wen;
    logic        done;
    logic [14:0] count;
    logic [1:0]  status;
  } scan_word_t;

  class scan_tracker;
    logic [3:0]  class_tab [256];
    logic [7:0]  shift_tab [256];
    bit          class_set [256];
    bit          shift_set [256];
    logic [14:0] position;
    bit          trail_due;
    bit          stopped;
    cfg_t        cfg;
    scan_word_t  pending_words [$];
    int          mismatches;

    function new();
      position = '0;
      trail_due = 1'b0;
      stopped = 1'b1;
      cfg = '0;
      cfg.buffer_length = 15'd1;
      mismatches = 0;
      for (int i = 0; i < 256; i++) begin
        class_set[i] = 1'b0;
        shift_set[i] = 1'b0;
      end
    endfunction

    task report(string msg);
      $display("[%0t] scan check: %s", $realtime, msg);
      mismatches++;
    endtask

    function void set_register(logic [2:0] idx, logic [14:0] val);
      case (idx)
        CFG_CLASS_SELECT:  cfg.class_select = val[5:0];
        CFG_STOP_ON_MATCH: cfg.stop_on_match = val[0];
        CFG_CASE_SHIFT:    cfg.case_shift = val[1:0];
        CFG_MOVE_ENABLE:   cfg.move_enable = val[0];
        CFG_BUFFER_LENGTH: cfg.buffer_length = val;
        default: ;
      endcase
    endfunction

    // class membership under the current selection mask
    function bit selected(logic [3:0] cls);
      logic [5:0] s;
      s = cfg.class_select;
      case (cls)
        CLS_UPPER:   return s[0] | s[4];
        CLS_LOWER:   return s[1] | s[4];
        CLS_NUMERIC: return s[2] | s[4];
        CLS_LEAD:    return s[5];
        default:     return (cls <= CLS_CONTROL) ? (s[3] | s[4]) : 1'b0;
      endcase
    endfunction

    // true when a tested byte of this class lets the scan go on
    function bit continues(logic [3:0] cls);
      if (cfg.class_select == ALL_CLASSES) return 1'b1;
      if (cfg.class_select != '0 && cls > CLS_LEAD) return 1'b0;
      return selected(cls) != cfg.stop_on_match;
    endfunction

    function void emit(logic [7:0] b, logic w, logic d, logic [14:0] c, logic [1:0] s);
      pending_words.push_back({b, w, d, c, s});
    endfunction

    function void apply_word(logic [1:0] op, logic [7:0] idx, logic [7:0] val,
                             logic [7:0] dat, logic sob);
      logic [3:0] cls;
      logic [7:0] ob;
      logic       mv;
      if (op == OP_LOAD_CLASS) begin
        class_tab[idx] = val[3:0];
        class_set[idx] = 1'b1;
        return;
      end
      if (op == OP_LOAD_SHIFT) begin
        shift_tab[idx] = val;
        shift_set[idx] = 1'b1;
        return;
      end
      if (op != OP_DATA) return;
      if (sob) begin
        position = '0;
        trail_due = 1'b0;
        stopped = 1'b0;
      end else if (stopped) begin
        return;
      end
      mv = cfg.move_enable;
      if (position >= cfg.buffer_length) begin
        stopped = 1'b1;
        emit(8'h00, 1'b0, 1'b1, position, ST_OK);
        return;
      end
      // second byte of a pair: passed through, no test
      if (trail_due) begin
        trail_due = 1'b0;
        position = position + 15'd1;
        if (position >= cfg.buffer_length) begin
          stopped = 1'b1;
          emit(mv ? dat : 8'h00, mv, 1'b1, position, ST_OK);
        end else begin
          emit(mv ? dat : 8'h00, mv, 1'b0, '0, ST_OK);
        end
        return;
      end
      cls = class_tab[dat];
      if (cfg.class_select != ALL_CLASSES) begin
        if (cfg.class_select != '0 && cls > CLS_LEAD) begin
          stopped = 1'b1;
          emit(8'h00, 1'b0, 1'b1, '0, ST_BAD_CLASS);
          return;
        end
        if (!continues(cls)) begin
          stopped = 1'b1;
          emit(8'h00, 1'b0, 1'b1, position, ST_OK);
          return;
        end
      end
      ob = (cfg.case_shift != 2'd0 && cls != CLS_LEAD) ? shift_tab[dat] : dat;
      if (cls == CLS_LEAD) begin
        if ({1'b0, position} + 16'd1 >= {1'b0, cfg.buffer_length}) begin
          stopped = 1'b1;
          emit(mv ? ob : 8'h00, mv, 1'b1, position, ST_LEAD_LAST);
          return;
        end
        trail_due = 1'b1;
        position = position + 15'd1;
        emit(mv ? ob : 8'h00, mv, 1'b0, '0, ST_OK);
        return;
      end
      position = position + 15'd1;
      if (position >= cfg.buffer_length) begin
        stopped = 1'b1;
        emit(mv ? ob : 8'h00, mv, 1'b1, position, ST_OK);
      end else begin
        emit(mv ? ob : 8'h00, mv, 1'b0, '0, ST_OK);
      end
    endfunction

    task check_word(scan_word_t got);
      scan_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("word with nothing expected, out_byte=%h", got.wbyte));
        return;
      end
      want = pending_words.pop_front();
      if (got.wbyte !== want.wbyte)
        report($sformatf("out_byte %h, want %h", got.wbyte, want.wbyte));
      if (got.wen !== want.wen)
        report($sformatf("write_enable %b, want %b", got.wen, want.wen));
      if (got.done !== want.done)
        report($sformatf("finished %b, want %b", got.done, want.done));
      if (got.count !== want.count)
        report($sformatf("char_count %0d, want %0d", got.count, want.count));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  op_i = OP_DATA;
  logic [7:0]  table_index_i = '0;
  logic [7:0]  table_value_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        start_of_buffer_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_byte_o;
  logic        write_enable_o;
  logic        finished_o;
  logic [14:0] char_count_o;
  logic [1:0]  status_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = CFG_CLASS_SELECT;
  logic [14:0] cfg_data_i = '0;

  scan_tracker tracker;
  int          words_sent;
  bit          tx_steady;
  logic        rx_steady = 1'b0;
  int          rx_hold = 0;

  char_class_scan_move u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .table_index_i,
    .table_value_i,
    .data_byte_i,
    .start_of_buffer_i,
    .out_valid_o,
    .out_ready_i,
    .out_byte_o,
    .write_enable_o,
    .finished_o,
    .char_count_o,
    .status_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("char_class_scan_move: mismatch");
    $finish;
  end

  // output side: check taken words, then stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      tracker.check_word({out_byte_o, write_enable_o, finished_o, char_count_o, status_o});
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_hold = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic int tx_gap();
    int roll;
    if (tx_steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [7:0] idx, input logic [7:0] val,
                           input logic [7:0] dat, input logic sob);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    table_index_i <= idx;
    table_value_i <= val;
    data_byte_i <= dat;
    start_of_buffer_i <= sob;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_LOAD_CLASS || op == OP_LOAD_SHIFT ||
        (op == OP_DATA && (sob || !tracker.stopped)))
      words_sent++;
    tracker.apply_word(op, idx, val, dat, sob);
  endtask

  task automatic send_data(input logic [7:0] dat, input logic sob);
    send_word(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), dat, sob);
  endtask

  task automatic seed_entry(input logic [7:0] idx, input logic [7:0] cls, input logic [7:0] shf);
    send_word(OP_LOAD_CLASS, idx, cls, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_word(OP_LOAD_SHIFT, idx, shf, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // all words out, then let loads and dropped bytes clear the pipeline
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [5:0] sel, input logic stop, input logic [1:0] shf,
                            input logic mv, input logic [14:0] len);
    logic [2:0]  regs [5];
    logic [14:0] vals [5];
    regs[0] = CFG_CLASS_SELECT;  vals[0] = {9'd0, sel};
    regs[1] = CFG_STOP_ON_MATCH; vals[1] = {14'd0, stop};
    regs[2] = CFG_CASE_SHIFT;    vals[2] = {13'd0, shf};
    regs[3] = CFG_MOVE_ENABLE;   vals[3] = {14'd0, mv};
    regs[4] = CFG_BUFFER_LENGTH; vals[4] = len;
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      tracker.set_register(regs[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Next data byte: any value for a pair's second byte, else a byte with both
  // table entries loaded, preferring one that keeps the scan going.
  function automatic logic [7:0] pick_byte(input bit sob, input bit keep_going);
    logic [7:0] pool [$];
    logic [7:0] good [$];
    if (!sob && !tracker.stopped && tracker.trail_due &&
        tracker.position < tracker.cfg.buffer_length)
      return 8'($urandom_range(0, 255));
    for (int i = 0; i < 256; i++) begin
      if (tracker.class_set[i] && tracker.shift_set[i]) begin
        pool.push_back(i[7:0]);
        if (tracker.continues(tracker.class_tab[i])) good.push_back(i[7:0]);
      end
    end
    if (keep_going && good.size() > 0) return good[$urandom_range(0, good.size() - 1)];
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  task automatic load_entries();
    logic [7:0] idx;
    logic [7:0] cv;
    idx = 8'($urandom_range(0, 255));
    cv = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 6) != 0) cv[3:0] = 4'($urandom_range(0, 6));
    send_word(OP_LOAD_CLASS, idx, cv, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) != 0)
      send_word(OP_LOAD_SHIFT, idx, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
  endtask

  task automatic run_buffer();
    bit sob;
    int n;
    sob = tracker.stopped || ($urandom_range(0, 4) != 0);
    send_data(pick_byte(sob, $urandom_range(0, 19) != 0), sob);
    n = 0;
    while (!tracker.stopped && n < 24 && $urandom_range(0, 39) != 0) begin
      if ($urandom_range(0, 24) == 0) load_entries();
      send_data(pick_byte(1'b0, $urandom_range(0, 19) != 0), 1'b0);
      n++;
    end
  endtask

  initial begin
    logic [5:0]  sel;
    logic [14:0] len;
    int          phase_goal;
    int          roll;
    bit          drained;
    tracker = new();
    words_sent = 0;
    tx_steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tables with every class code, then the corner cases
    write_regs(ALL_CLASSES, 1'b0, 2'd1, 1'b1, 15'd4);
    seed_entry(8'h30, 8'h00, 8'h30);
    seed_entry(8'h41, 8'h01, 8'h61);
    seed_entry(8'h61, 8'h02, 8'h41);
    seed_entry(8'h21, 8'h93, 8'h21);
    seed_entry(8'h40, 8'h04, 8'h40);
    seed_entry(8'h0a, 8'h05, 8'h0a);
    seed_entry(8'hc8, 8'h06, 8'hc8);
    seed_entry(8'h80, 8'h07, 8'h00);
    seed_entry(8'hff, 8'hff, 8'hff);
    seed_entry(8'h00, 8'hf0, 8'h7f);
    // all classes: pair inside the buffer, ends on length
    send_data(8'h41, 1'b1);
    send_data(8'hc8, 1'b0);
    send_data(8'h55, 1'b0);
    send_data(8'h61, 1'b0);
    wait_idle();
    // zero length, then a stray byte and the unused op
    write_regs(6'd0, 1'b0, 2'd0, 1'b0, 15'd0);
    send_data(8'h30, 1'b1);
    send_data(8'h41, 1'b0);
    send_word(OP_UNUSED, 8'hff, 8'hff, 8'hff, 1'b1);
    wait_idle();
    // nothing selected, until mode: no validity check, runs to length
    write_regs(6'd0, 1'b1, 2'd3, 1'b1, 15'd3);
    send_data(8'hff, 1'b1);
    send_data(8'h80, 1'b0);
    send_data(8'h30, 1'b0);
    wait_idle();
    // nothing selected, while mode: stops on the first byte
    write_regs(6'd0, 1'b0, 2'd0, 1'b1, 15'd5);
    send_data(8'h41, 1'b1);
    wait_idle();
    // upper only, longest buffer: stop on lower, then an invalid code
    write_regs(6'h01, 1'b0, 2'd2, 1'b1, 15'h7fff);
    send_data(8'h41, 1'b1);
    send_data(8'h41, 1'b0);
    send_data(8'h61, 1'b0);
    send_data(8'h80, 1'b1);
    wait_idle();
    // restart mid-scan, then a lead byte in the last place
    write_regs(ALL_CLASSES, 1'b0, 2'd0, 1'b1, 15'd2);
    send_data(8'h41, 1'b1);
    send_data(8'h41, 1'b1);
    send_data(8'hc8, 1'b0);

    // random phases
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      tx_steady = (p == 6);
      rx_steady <= (p == 6);
      case (p)
        0: sel = ALL_CLASSES;
        1: sel = 6'd0;
        6: sel = 6'h01;
        default: sel = 6'($urandom_range(0, 63));
      endcase
      case (p)
        3: len = 15'h7fff;
        5: len = 15'd0;
        7: len = 15'd1;
        default: len = 15'($urandom_range(1, 10));
      endcase
      write_regs(sel, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                 p[0] | ($urandom_range(0, 2) == 0), len);
      phase_goal = words_sent + 95;
      drained = 1'b0;
      // keep a scan that ran across the settings change going
      if (!tracker.stopped) send_data(pick_byte(1'b0, 1'b1), 1'b0);
      while (words_sent < phase_goal) begin
        if (!drained && words_sent > phase_goal - 50) begin
          wait_idle();
          drained = 1'b1;
        end
        roll = $urandom_range(0, 99);
        if (roll < 12)
          load_entries();
        else if (roll < 15)
          send_word(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        else if (roll < 20 && tracker.stopped)
          send_data(pick_byte(1'b0, 1'b1), 1'b0);
        else
          run_buffer();
      end
    end

    wait_idle();
    if (tracker.mismatches == 0) begin
      $display("char_class_scan_move: match");
    end else begin
      $display("char_class_scan_move: mismatch");
    end
    $finish;
  end

endmodule
